>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl modules
// expects clk and rst_n in the scope of each use; empty bodies for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> hw/rtl/euu_pkg.sv
// shared types and constants for the escape unescaper
// no dependencies
package euu_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef logic [7:0] byte_t;

    // one decoded input transaction: up to three output bytes and the end flag
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            last;
    } q_entry_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

>>> hw/rtl/euu_in_if.sv
// input channel: raw escaped bytes with an end-of-value flag
// no dependencies
interface euu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_value;

    modport source (output valid, output char_byte, output end_of_value, input ready);
    modport sink (input valid, input char_byte, input end_of_value, output ready);
endinterface

>>> hw/rtl/euu_out_if.sv
// output channel: unescaped bytes, end-only markers and the last flag
// no dependencies
interface euu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_value;

    modport source (output valid, output out_byte, output byte_valid, output last_of_value,
                     input ready);
    modport sink (input valid, input out_byte, input byte_valid, input last_of_value,
                  output ready);
endinterface

>>> hw/rtl/escape_unescape_to_utf8.sv
// path: an accepted input goes into the queue slot, then into the output register
// throughput: one input byte per cycle while the queue has room; the output register sends
// one byte per cycle while the sink is ready, so a unicode escape giving two or three bytes
// holds the output longer and the four-entry queue between scanner and output absorbs those bursts
// reset: asynchronous active-low rst_n clears the scanner mode, queue and output valid
// top level: scanner front end, decoded-entry queue, byte serialiser back end
module escape_unescape_to_utf8 #(
    parameter int QueueDepth = euu_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    euu_in_if.sink     escaped,
    euu_out_if.source  unescaped
);
    import euu_pkg::*;

    q_entry_t     push_data;
    q_entry_t     head;
    fifo_status_t q_status;
    logic         q_push;
    logic         q_pop;

    euu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .escaped  (escaped),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    euu_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (head),
        .status    (q_status)
    );

    euu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .unescaped (unescaped)
    );

endmodule

>>> hw/rtl/euu_front.sv
// front end: accepts raw bytes, runs the escape scanner, builds queue entries
// depends on euu_pkg and euu_in_if
module euu_front (
    input  logic                   clk,
    input  logic                   rst_n,
    euu_in_if.sink                 escaped,
    input  euu_pkg::fifo_status_t  q_status,
    output logic                   q_push,
    output euu_pkg::q_entry_t      q_data
);
    import euu_pkg::*;

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_ESCAPE  = 2'd1;
    localparam logic [1:0] MODE_UNICODE = 2'd2;

    localparam byte_t CHAR_BSLASH = 8'h5C;
    localparam byte_t CHAR_U      = 8'h75;
    localparam byte_t CHAR_T      = 8'h74;
    localparam byte_t CHAR_N      = 8'h6E;
    localparam byte_t CHAR_R      = 8'h72;
    localparam byte_t CHAR_F      = 8'h66;
    localparam byte_t CODE_TAB    = 8'h09;
    localparam byte_t CODE_LF     = 8'h0A;
    localparam byte_t CODE_CR     = 8'h0D;
    localparam byte_t CODE_FF     = 8'h0C;
    localparam byte_t LEAD_TWO    = 8'hC0;
    localparam byte_t LEAD_THREE  = 8'hE0;
    localparam byte_t CONT_MARK   = 8'h80;

    typedef struct packed {
        logic  emit;
        byte_t data;
        logic  esc;
    } step_t;

    // {is hex, nibble}; nibble is zero for a non-hex byte
    function automatic logic [4:0] hex_decode(input byte_t c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end
        else if ((c inside {[8'h61:8'h66]}) || (c inside {[8'h41:8'h46]})) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic byte_t esc_map(input byte_t c);
        byte_t r;
        case (c)
            CHAR_T:  r = CODE_TAB;
            CHAR_N:  r = CODE_LF;
            CHAR_R:  r = CODE_CR;
            CHAR_F:  r = CODE_FF;
            default: r = c;
        endcase
        return r;
    endfunction

    // one byte in normal or after-backslash mode; \u is handled by the caller
    function automatic step_t char_step(input logic esc, input byte_t c, input logic is_end);
        step_t s;
        s.emit = 1'b0;
        s.data = c;
        s.esc  = 1'b0;
        if (esc) begin
            if (c != CHAR_U) begin
                s.emit = 1'b1;
                s.data = esc_map(c);
            end
        end
        else if (c == CHAR_BSLASH) begin
            s.esc = !is_end;
        end
        else begin
            s.emit = 1'b1;
        end
        return s;
    endfunction

    function automatic q_entry_t utf8_encode(input logic [15:0] cp);
        q_entry_t e;
        e = '0;
        if (cp <= 16'h007F) begin
            e.bytes[0] = cp[7:0];
            e.count    = 2'd1;
        end
        else if (cp <= 16'h07FF) begin
            e.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
            e.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
            e.count    = 2'd2;
        end
        else begin
            e.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
            e.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
            e.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
            e.count    = 2'd3;
        end
        return e;
    endfunction

    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] accum_reg, accum_next;
    logic        bad_reg, bad_next;
    byte_t       held_reg [3];
    logic        held_wr;

    logic        accept;
    byte_t       in_b;
    logic        in_end;
    logic [4:0]  hexd;
    logic [15:0] acc_shift;
    step_t       st;
    step_t       rep_st;
    logic        rep_esc;
    logic [1:0]  rep_k;
    byte_t       rep_byte;
    q_entry_t    ent;

    assign in_b          = escaped.char_byte;
    assign in_end        = escaped.end_of_value;
    assign escaped.ready = !q_status.full;
    assign accept        = escaped.valid && escaped.ready;
    assign hexd          = hex_decode(in_b);
    assign acc_shift     = {accum_reg[11:0], hexd[3:0]};

    // scanner next state and decoded bytes
    always_comb
    begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        accum_next = accum_reg;
        bad_next   = bad_reg;
        held_wr    = 1'b0;
        ent        = '0;
        st         = '0;
        rep_st     = '0;
        rep_esc    = 1'b0;
        rep_k      = 2'd0;
        rep_byte   = in_b;
        if (mode_reg == MODE_UNICODE) begin
            accum_next = acc_shift;
            bad_next   = bad_reg | !hexd[4];
            if (cnt_reg == 2'd3) begin
                mode_next = MODE_NORMAL;
                cnt_next  = 2'd0;
                if (!bad_next) begin
                    ent = utf8_encode(acc_shift);
                end
            end
            else if (in_end) begin
                // short escape: replay held digits and this byte as plain input
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) <= cnt_reg) begin
                        rep_byte = (2'(i) == cnt_reg) ? in_b : held_reg[2'(i)];
                        rep_st   = char_step(rep_esc, rep_byte, 2'(i) == cnt_reg);
                        rep_esc  = rep_st.esc;
                        if (rep_st.emit) begin
                            ent.bytes[rep_k] = rep_st.data;
                            rep_k            = rep_k + 2'd1;
                        end
                    end
                end
                ent.count = rep_k;
            end
            else begin
                held_wr  = 1'b1;
                cnt_next = cnt_reg + 2'd1;
            end
        end
        else begin
            st        = char_step(mode_reg == MODE_ESCAPE, in_b, in_end);
            mode_next = st.esc ? MODE_ESCAPE : MODE_NORMAL;
            if ((mode_reg == MODE_ESCAPE) && (in_b == CHAR_U) && !in_end) begin
                mode_next  = MODE_UNICODE;
                cnt_next   = 2'd0;
                accum_next = 16'd0;
                bad_next   = 1'b0;
            end
            if (st.emit) begin
                ent.bytes[0] = st.data;
                ent.count    = 2'd1;
            end
        end
        if (in_end) begin
            mode_next = MODE_NORMAL;
            cnt_next  = 2'd0;
        end
        ent.last = in_end;
    end

    // only transactions that give bytes or close a value enter the queue
    assign q_push = accept && ((ent.count != 2'd0) || in_end);
    assign q_data = ent;

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_NORMAL;
            cnt_reg   <= 2'd0;
            accum_reg <= 16'd0;
            bad_reg   <= 1'b0;
        end
        else if (accept) begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            accum_reg <= accum_next;
            bad_reg   <= bad_next;
        end
    end

    // held raw digits
    always_ff @(posedge clk)
    begin
        if (accept && held_wr) begin
            held_reg[cnt_reg] <= in_b;
        end
    end

endmodule

>>> hw/rtl/euu_fifo.sv
// short queue of decoded entries between the front and back ends
// depends on euu_pkg and assert_macros.svh
`include "assert_macros.svh"
module euu_fifo #(
    parameter int Depth = euu_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  euu_pkg::q_entry_t     push_data,
    input  logic                  pop,
    output euu_pkg::q_entry_t     pop_data,
    output euu_pkg::fifo_status_t status
);
    import euu_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    q_entry_t          slot_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [CntW-1:0]   count_reg;
    logic              push_ok;
    logic              pop_ok;

    assign status.full  = (count_reg == CntW'(Depth));
    assign status.empty = (count_reg == '0);
    assign push_ok      = push && !status.full;
    assign pop_ok       = pop && !status.empty;
    assign pop_data     = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push_ok) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_ok) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_ok && !push_ok) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push_ok) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_ALWAYS(a_count_range, count_reg <= CntW'(Depth), "queue fill count beyond depth")
    `ASSERT_NEXT(a_count_up, push_ok && !pop_ok, count_reg == $past(count_reg) + 1'b1, "queue count did not rise on push")
    `ASSERT_NEXT(a_count_down, pop_ok && !push_ok, count_reg == $past(count_reg) - 1'b1, "queue count did not fall on pop")

endmodule

>>> hw/rtl/euu_back.sv
// back end: walks the bytes of each queue entry into the output register
// depends on euu_pkg, euu_out_if and assert_macros.svh
`include "assert_macros.svh"
module euu_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  euu_pkg::q_entry_t     head,
    input  euu_pkg::fifo_status_t q_status,
    output logic                  q_pop,
    euu_out_if.source             unescaped
);
    import euu_pkg::*;

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    byte_t      out_byte_reg;
    logic       byte_valid_reg;
    logic       last_reg;
    logic       load;
    logic       take;
    logic [1:0] last_idx;
    logic       at_end;

    // output register may load when empty or being drained
    assign load     = !out_valid_reg || unescaped.ready;
    assign take     = load && !q_status.empty;
    assign last_idx = (head.count == 2'd0) ? 2'd0 : head.count - 2'd1;
    assign at_end   = (idx_reg == last_idx);
    assign q_pop    = take && at_end;

    assign unescaped.valid         = out_valid_reg;
    assign unescaped.out_byte      = out_byte_reg;
    assign unescaped.byte_valid    = byte_valid_reg;
    assign unescaped.last_of_value = last_reg;

    // byte index and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (load) begin
                out_valid_reg <= !q_status.empty;
            end
            if (take) begin
                idx_reg <= at_end ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    // output payload; an entry with no bytes becomes an end-only marker
    always_ff @(posedge clk)
    begin
        if (take) begin
            out_byte_reg   <= (head.count == 2'd0) ? 8'h00 : head.bytes[idx_reg];
            byte_valid_reg <= (head.count != 2'd0);
            last_reg       <= head.last && at_end;
        end
    end

    `ASSERT_IMPLIES(a_marker_last, out_valid_reg && !byte_valid_reg, last_reg, "end-only marker without last flag")
    `ASSERT_IMPLIES(a_idx_has_head, idx_reg != 2'd0, !q_status.empty, "byte index set with empty queue")

endmodule
